FILE: rtl/qrr_pkg.sv
// Shared types, widths and constants for the quintic rest-to-rest profile generator.
package qrr_pkg;

    localparam int MAX_STEPS   = 63;
    localparam int ANGLE_W     = 20;
    localparam int DELTA_W     = 21;
    localparam int IDX_W       = 6;
    localparam int PH_W        = 17;
    localparam int FRAC        = 16;
    localparam int ONE_Q16     = 65536;
    localparam int TABLE_N     = 1 << IDX_W;
    localparam int BLEND_W     = 22;
    localparam int PROD_W      = 43;
    localparam int SUM_W       = 28;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int PIPE_LAST   = 7;

    localparam logic [IDX_W-1:0] NUM_STEPS_RST = IDX_W'(MAX_STEPS);

    localparam logic signed [BLEND_W-1:0] C_S3 = 22'sd10;
    localparam logic signed [BLEND_W-1:0] C_S4 = 22'sd15;
    localparam logic signed [BLEND_W-1:0] C_S5 = 22'sd6;

    localparam logic signed [SUM_W-1:0] ANGLE_MAX = 28'sd524287;
    localparam logic signed [SUM_W-1:0] ANGLE_MIN = -28'sd524288;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] start;
        logic signed [DELTA_W-1:0] delta;
        logic [IDX_W-1:0]          n;
        logic [PH_W-1:0]           step_q;
        logic [IDX_W-1:0]          step_r;
    } t_job;

    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic                      last;
        logic signed [ANGLE_W-1:0] start;
        logic signed [DELTA_W-1:0] delta;
    } t_tag;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/qrr_front.sv
// Front end: step-count register, input accept, delta and phase-step lookup per move.
module qrr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [qrr_pkg::IDX_W-1:0]           i_cfg_data,
    output logic                                o_cfg_ready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [qrr_pkg::ANGLE_W-1:0]  i_start_angle,
    input  logic signed [qrr_pkg::ANGLE_W-1:0]  i_target_angle,
    input  qrr_pkg::t_q_stat                    i_q_stat,
    output logic                                o_push,
    output qrr_pkg::t_job                       o_job
);

    logic [qrr_pkg::IDX_W-1:0] r_num_steps;
    logic [qrr_pkg::IDX_W-1:0] w_n;
    logic [qrr_pkg::PH_W-1:0]  w_tq [qrr_pkg::TABLE_N];
    logic [qrr_pkg::IDX_W-1:0] w_tr [qrr_pkg::TABLE_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_steps <= qrr_pkg::NUM_STEPS_RST;
        end else if (i_cfg_valid) begin
            r_num_steps <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // 65536 / n split into quotient and remainder, one entry per step count
    for (genvar g = 0; g < qrr_pkg::TABLE_N; g++) begin : g_rcp
        localparam int Dv = (g == 0) ? 1 : g;
        assign w_tq[g] = qrr_pkg::PH_W'(qrr_pkg::ONE_Q16 / Dv);
        assign w_tr[g] = qrr_pkg::IDX_W'(qrr_pkg::ONE_Q16 % Dv);
    end

    always_comb begin
        if (r_num_steps == '0) begin
            w_n = qrr_pkg::IDX_W'(1);
        end else if (int'(r_num_steps) > qrr_pkg::MAX_STEPS) begin
            w_n = qrr_pkg::IDX_W'(qrr_pkg::MAX_STEPS);
        end else begin
            w_n = r_num_steps;
        end
    end

    assign o_in_stall   = i_q_stat.full;
    assign o_push       = i_in_valid && !i_q_stat.full;
    assign o_job.start  = i_start_angle;
    assign o_job.delta  = qrr_pkg::DELTA_W'(i_target_angle) - qrr_pkg::DELTA_W'(i_start_angle);
    assign o_job.n      = w_n;
    assign o_job.step_q = w_tq[w_n];
    assign o_job.step_r = w_tr[w_n];

endmodule

FILE: rtl/qrr_queue.sv
// Two-entry job queue between the front end and the sample engine.
module qrr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qrr_pkg::t_job    i_job,
    input  logic             i_pop,
    output qrr_pkg::t_job    o_head,
    output qrr_pkg::t_q_stat o_stat
);

    qrr_pkg::t_job              r_mem [qrr_pkg::QUEUE_DEPTH];
    logic [qrr_pkg::QPTR_W-1:0] r_wptr;
    logic [qrr_pkg::QPTR_W-1:0] r_rptr;
    logic [qrr_pkg::QCNT_W-1:0] r_cnt;
    logic                       w_do_push;
    logic                       w_do_pop;

    assign o_stat.full  = (r_cnt == qrr_pkg::QCNT_W'(qrr_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/qrr_back.sv
// Sample engine: phase sequencer, power/blend pipeline, scaling, saturation, output register.
module qrr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  qrr_pkg::t_job                       i_head,
    input  qrr_pkg::t_q_stat                    i_q_stat,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [qrr_pkg::ANGLE_W-1:0]  o_angle,
    output logic [qrr_pkg::IDX_W-1:0]           o_step_index,
    output logic                                o_last
);

    localparam int PW = 2 * qrr_pkg::PH_W;

    logic                        w_en;
    logic                        w_issue;
    logic                        r_busy;
    logic [qrr_pkg::PIPE_LAST:0] r_vld;
    qrr_pkg::t_job               r_job;
    logic [qrr_pkg::IDX_W-1:0]   r_i;
    logic [qrr_pkg::PH_W-1:0]    r_acc;
    logic [qrr_pkg::IDX_W-1:0]   r_rem;
    logic [qrr_pkg::IDX_W:0]     w_rsum;
    logic                        w_wrap;
    logic [qrr_pkg::IDX_W-1:0]   n_rem;
    logic [qrr_pkg::PH_W-1:0]    n_acc;
    logic                        w_is_last;

    qrr_pkg::t_tag               r_tag [qrr_pkg::PIPE_LAST+1];

    logic [qrr_pkg::PH_W-1:0]    r_s0, r_s1, r_s2, r_s3;
    logic [qrr_pkg::PH_W-1:0]    r_sq1, r_cu2, r_cu3, r_cu4, r_qu3, r_qu4, r_fi4;
    logic [PW-1:0]               w_p1, w_p2, w_p3, w_p4;
    logic signed [qrr_pkg::BLEND_W-1:0] w_blend, r_blend;
    logic signed [qrr_pkg::PROD_W-1:0]  w_prod, r_prod, w_shift;
    logic signed [qrr_pkg::SUM_W-1:0]   w_sum;
    logic signed [qrr_pkg::ANGLE_W-1:0] r_angle, w_sat;

    assign w_en      = !(r_vld[qrr_pkg::PIPE_LAST] && i_out_stall);
    assign w_issue   = w_en && r_busy;
    assign o_pop     = w_en && !r_busy && !i_q_stat.empty;
    assign w_is_last = (r_i == r_job.n);

    // next phase = floor((i+1) * 65536 / n), kept as quotient plus remainder
    assign w_rsum = {1'b0, r_rem} + {1'b0, r_job.step_r};
    assign w_wrap = (w_rsum >= {1'b0, r_job.n});
    assign n_rem  = w_wrap ? qrr_pkg::IDX_W'(w_rsum - {1'b0, r_job.n}) : w_rsum[qrr_pkg::IDX_W-1:0];
    assign n_acc  = r_acc + r_job.step_q + qrr_pkg::PH_W'(w_wrap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[qrr_pkg::PIPE_LAST-1:0], r_busy};
            if (!r_busy) begin
                r_busy <= !i_q_stat.empty;
            end else if (w_is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
            r_i   <= '0;
            r_acc <= '0;
            r_rem <= '0;
        end else if (w_issue) begin
            r_i   <= r_i + 1'b1;
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign w_p1 = {{qrr_pkg::PH_W{1'b0}}, r_s0}  * {{qrr_pkg::PH_W{1'b0}}, r_s0};
    assign w_p2 = {{qrr_pkg::PH_W{1'b0}}, r_sq1} * {{qrr_pkg::PH_W{1'b0}}, r_s1};
    assign w_p3 = {{qrr_pkg::PH_W{1'b0}}, r_cu2} * {{qrr_pkg::PH_W{1'b0}}, r_s2};
    assign w_p4 = {{qrr_pkg::PH_W{1'b0}}, r_qu3} * {{qrr_pkg::PH_W{1'b0}}, r_s3};

    assign w_blend = $signed({{(qrr_pkg::BLEND_W-qrr_pkg::PH_W){1'b0}}, r_cu4}) * qrr_pkg::C_S3
                   - $signed({{(qrr_pkg::BLEND_W-qrr_pkg::PH_W){1'b0}}, r_qu4}) * qrr_pkg::C_S4
                   + $signed({{(qrr_pkg::BLEND_W-qrr_pkg::PH_W){1'b0}}, r_fi4}) * qrr_pkg::C_S5;

    assign w_prod  = qrr_pkg::PROD_W'($signed(r_tag[5].delta)) * qrr_pkg::PROD_W'(r_blend);
    assign w_shift = r_prod >>> qrr_pkg::FRAC;
    assign w_sum   = qrr_pkg::SUM_W'(w_shift) + qrr_pkg::SUM_W'($signed(r_tag[6].start));

    always_comb begin
        if (w_sum > qrr_pkg::ANGLE_MAX) begin
            w_sat = qrr_pkg::ANGLE_W'(qrr_pkg::ANGLE_MAX);
        end else if (w_sum < qrr_pkg::ANGLE_MIN) begin
            w_sat = qrr_pkg::ANGLE_W'(qrr_pkg::ANGLE_MIN);
        end else begin
            w_sat = w_sum[qrr_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_busy) begin
                r_s0            <= r_acc;
                r_tag[0].idx    <= r_i;
                r_tag[0].last   <= w_is_last;
                r_tag[0].start  <= r_job.start;
                r_tag[0].delta  <= r_job.delta;
            end
            for (int k = 1; k <= qrr_pkg::PIPE_LAST; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            r_s1    <= r_s0;
            r_sq1   <= w_p1[2*qrr_pkg::FRAC:qrr_pkg::FRAC];
            r_s2    <= r_s1;
            r_cu2   <= w_p2[2*qrr_pkg::FRAC:qrr_pkg::FRAC];
            r_s3    <= r_s2;
            r_cu3   <= r_cu2;
            r_qu3   <= w_p3[2*qrr_pkg::FRAC:qrr_pkg::FRAC];
            r_cu4   <= r_cu3;
            r_qu4   <= r_qu3;
            r_fi4   <= w_p4[2*qrr_pkg::FRAC:qrr_pkg::FRAC];
            r_blend <= w_blend;
            r_prod  <= w_prod;
            r_angle <= w_sat;
        end
    end

    assign o_out_valid  = r_vld[qrr_pkg::PIPE_LAST];
    assign o_angle      = r_angle;
    assign o_step_index = r_tag[qrr_pkg::PIPE_LAST].idx;
    assign o_last       = r_tag[qrr_pkg::PIPE_LAST].last;

endmodule

FILE: rtl/quintic_rest_to_rest_profile.sv
// Top level of the quintic rest-to-rest joint profile generator.
// Input channel (i_in_valid / o_in_stall): one word is a move, start and target angle
// in signed Q3.16 radians. Output channel (o_out_valid / i_out_stall): one word per
// sample, angle plus step index, with o_last on the final sample of the move.
// Config channel (i_cfg_valid / o_cfg_ready): writes num_steps; ready is always high.
// Write it only while no move is in flight. A value of 0 acts as 1.
// Each move yields num_steps+1 samples. The phase sequencer fetches each job from the
// two-entry queue and then issues one sample per cycle while the output is not stalled;
// it fetches the next job only after the last sample of the move is issued. Samples pass
// through an eight-stage pipeline of phase, power, blend, product and angle registers.
// Up to two further moves wait in the queue while the engine runs; o_in_stall rises
// when the queue is full. A stall on the output while a sample is valid freezes the
// whole engine pipeline, holding the sample on the port.
// Reset sets num_steps to 63 and empties the queue and pipeline.
module quintic_rest_to_rest_profile (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [qrr_pkg::IDX_W-1:0]           i_cfg_data,
    output logic                                o_cfg_ready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [qrr_pkg::ANGLE_W-1:0]  i_start_angle,
    input  logic signed [qrr_pkg::ANGLE_W-1:0]  i_target_angle,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [qrr_pkg::ANGLE_W-1:0]  o_angle,
    output logic [qrr_pkg::IDX_W-1:0]           o_step_index,
    output logic                                o_last
);

    qrr_pkg::t_q_stat w_q_stat;
    qrr_pkg::t_job    w_job;
    qrr_pkg::t_job    w_head;
    logic             w_push;
    logic             w_pop;

    qrr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_angle  (i_start_angle),
        .i_target_angle (i_target_angle),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_job          (w_job)
    );

    qrr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    qrr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_angle      (o_angle),
        .o_step_index (o_step_index),
        .o_last       (o_last)
    );

endmodule

FILE: rtl/qrr_checker.sv
// Port-level checker for the profile generator, bound to the top level.
module qrr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_valid,
    input logic [qrr_pkg::IDX_W-1:0]           i_cfg_data,
    input logic                                o_cfg_ready,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [qrr_pkg::ANGLE_W-1:0]  o_angle,
    input logic [qrr_pkg::IDX_W-1:0]           o_step_index,
    input logic                                o_last
);

    logic [qrr_pkg::IDX_W-1:0] r_n;
    logic [qrr_pkg::IDX_W-1:0] r_exp_idx;
    logic [qrr_pkg::IDX_W-1:0] w_eff_n;
    logic                      w_out_acc;

    assign w_out_acc = o_out_valid && !i_out_stall;
    assign w_eff_n   = (r_n == '0) ? qrr_pkg::IDX_W'(1) : r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= qrr_pkg::NUM_STEPS_RST;
            r_exp_idx <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_n <= i_cfg_data;
            end
            if (w_out_acc) begin
                r_exp_idx <= o_last ? '0 : r_exp_idx + 1'b1;
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_angle)
            && $stable(o_step_index) && $stable(o_last))
        else $error("stalled sample changed");

    a_seq_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_step_index == r_exp_idx)
        else $error("sample index out of sequence");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_step_index == w_eff_n)
        else $error("last flag not on final step");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_step_index == w_eff_n |-> o_last)
        else $error("final step missing last flag");

endmodule

bind quintic_rest_to_rest_profile qrr_checker u_qrr_checker (.*);

FILE: tb/tb_quintic_rest_to_rest_profile.sv
// Testbench for the quintic rest-to-rest profile generator: directed and random moves checked per sample.
`timescale 1ns / 1ps

module tb_quintic_rest_to_rest_profile;

    localparam int     QUIET_LIMIT = 5000;
    localparam longint BLEND_C3    = 10;
    localparam longint BLEND_C4    = 15;
    localparam longint BLEND_C5    = 6;
    localparam longint ANGLE_HI    = 524287;
    localparam longint ANGLE_LO    = -524288;

    typedef struct packed {
        logic signed [qrr_pkg::ANGLE_W-1:0] angle;
        logic [qrr_pkg::IDX_W-1:0]          idx;
        logic                               last;
    } t_sample;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_cfg_valid    = 1'b0;
    logic [qrr_pkg::IDX_W-1:0]           i_cfg_data     = '0;
    logic                                o_cfg_ready;
    logic                                i_in_valid     = 1'b0;
    logic                                o_in_stall;
    logic signed [qrr_pkg::ANGLE_W-1:0]  i_start_angle  = '0;
    logic signed [qrr_pkg::ANGLE_W-1:0]  i_target_angle = '0;
    logic                                o_out_valid;
    logic                                i_out_stall    = 1'b0;
    logic signed [qrr_pkg::ANGLE_W-1:0]  o_angle;
    logic [qrr_pkg::IDX_W-1:0]           o_step_index;
    logic                                o_last;

    t_sample                   samples_due[$];
    logic [qrr_pkg::IDX_W-1:0] steps_reg    = qrr_pkg::IDX_W'(63);
    int                        errors       = 0;
    int                        in_idle_pct  = 0;
    int                        out_idle_pct = 0;

    quintic_rest_to_rest_profile u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_angle  (i_start_angle),
        .i_target_angle (i_target_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_angle        (o_angle),
        .o_step_index   (o_step_index),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_sample quintic_sample(input logic signed [qrr_pkg::ANGLE_W-1:0] st,
                                               input logic signed [qrr_pkg::ANGLE_W-1:0] tg,
                                               input int n, input int k);
        longint  delta;
        longint  ph;
        longint  p2;
        longint  p3;
        longint  p4;
        longint  p5;
        longint  blend;
        longint  q;
        t_sample r;
        delta = longint'(tg) - longint'(st);
        ph    = (longint'(k) * qrr_pkg::ONE_Q16) / n;
        p2    = (ph * ph) >>> qrr_pkg::FRAC;
        p3    = (p2 * ph) >>> qrr_pkg::FRAC;
        p4    = (p3 * ph) >>> qrr_pkg::FRAC;
        p5    = (p4 * ph) >>> qrr_pkg::FRAC;
        blend = BLEND_C3 * p3 - BLEND_C4 * p4 + BLEND_C5 * p5;
        q     = longint'(st) + ((delta * blend) >>> qrr_pkg::FRAC);
        if (q > ANGLE_HI) q = ANGLE_HI;
        if (q < ANGLE_LO) q = ANGLE_LO;
        r.angle = q[qrr_pkg::ANGLE_W-1:0];
        r.idx   = k[qrr_pkg::IDX_W-1:0];
        r.last  = (k == n);
        return r;
    endfunction

    function automatic logic signed [qrr_pkg::ANGLE_W-1:0] pick_angle();
        logic signed [qrr_pkg::ANGLE_W-1:0] a;
        case ($urandom_range(0, 5))
            0: a = qrr_pkg::ANGLE_W'(ANGLE_LO);
            1: a = qrr_pkg::ANGLE_W'(ANGLE_HI);
            2: a = qrr_pkg::ANGLE_W'($urandom_range(0, 2000)) - 20'sd1000;
            default: a = qrr_pkg::ANGLE_W'($urandom);
        endcase
        return a;
    endfunction

    // one move word; valid stays high after acceptance until the next idle or drain
    task automatic send_move(input logic signed [qrr_pkg::ANGLE_W-1:0] st,
                             input logic signed [qrr_pkg::ANGLE_W-1:0] tg);
        int n;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_start_angle  <= st;
        i_target_angle <= tg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n = (steps_reg == 0) ? 1 : int'(steps_reg);
        for (int k = 0; k <= n; k++)
            samples_due.insert(samples_due.size(), quintic_sample(st, tg, n, k));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (samples_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_steps(input logic [qrr_pkg::IDX_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        steps_reg = v;
    endtask

    task automatic test_reset_steps();
        send_move(-20'sd524288, 20'sd524287);
        send_move(20'sd100000, -20'sd250000);
    endtask

    task automatic test_step_counts();
        wait_drain();
        write_steps(6'd0);
        send_move(20'sd1000, 20'sd70000);
        wait_drain();
        write_steps(6'd1);
        send_move(-20'sd524288, 20'sd524287);
        wait_drain();
        write_steps(6'd63);
        send_move(20'sd524287, -20'sd524288);
        wait_drain();
        write_steps(6'd2);
        send_move(-20'sd3, 20'sd65536);
    endtask

    task automatic test_angle_extremes();
        wait_drain();
        write_steps(6'd5);
        send_move(-20'sd524288, 20'sd524287);
        send_move(20'sd524287, -20'sd524288);
        send_move(20'sd0, 20'sd0);
        send_move(-20'sd1, 20'sd0);
        send_move(20'sd524287, 20'sd524287);
        send_move(-20'sd524288, -20'sd524288);
        send_move(20'sd12345, -20'sd6789);
    endtask

    task automatic test_random_moves(input int count);
        logic signed [qrr_pkg::ANGLE_W-1:0] st;
        for (int k = 0; k < count; k++) begin
            if (k % 12 == 0) begin
                wait_drain();
                case ($urandom_range(0, 7))
                    0: write_steps(6'd0);
                    1: write_steps(6'd63);
                    2: write_steps(6'd1);
                    3: write_steps(qrr_pkg::IDX_W'($urandom));
                    default: write_steps(qrr_pkg::IDX_W'($urandom_range(2, 20)));
                endcase
            end
            st = pick_angle();
            if ($urandom_range(0, 3) == 0)
                send_move(st, st ^ qrr_pkg::ANGLE_W'($urandom_range(0, 255)));
            else
                send_move(st, pick_angle());
        end
    endtask

    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_angle, o_step_index, o_last};
            if (samples_due.size() == 0) begin
                $error("unexpected sample: angle %0d step_index %0d last %0d",
                       got.angle, got.idx, got.last);
                errors++;
            end else begin
                want = samples_due.pop_front();
                if (got.angle !== want.angle) begin
                    $error("angle: expected %0d, got %0d", want.angle, got.angle);
                    errors++;
                end
                if (got.idx !== want.idx) begin
                    $error("step_index: expected %0d, got %0d", want.idx, got.idx);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[quintic_rest_to_rest_profile] ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_idle_pct  = 21;
        out_idle_pct = 59;
        test_reset_steps();
        test_step_counts();
        test_angle_extremes();
        test_random_moves(85);
        in_idle_pct  = 59;
        out_idle_pct = 21;
        test_random_moves(85);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_random_moves(80);
        wait_drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && samples_due.size() == 0) begin
            $display("[quintic_rest_to_rest_profile] OK");
        end else begin
            $display("[quintic_rest_to_rest_profile] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/qrr_pkg.sv
rtl/qrr_front.sv
rtl/qrr_queue.sv
rtl/qrr_back.sv
rtl/quintic_rest_to_rest_profile.sv
rtl/qrr_checker.sv
tb/tb_quintic_rest_to_rest_profile.sv
